[src/mmdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmdt_pkg - shared types and constants for the MAC move detect table
// Payload structs, result codes, queue sizing and the back-end state type.
// ----------------------------------------------------------------------------
package mmdt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned MAC_W    = 48;
  localparam int unsigned PORT_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned EIDX_W   = 8;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LEARNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [MAC_W-1:0]  mac_address;
    logic [PORT_W-1:0] port_number;
    logic              has_master;
    logic              has_mac;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   previous_port;
    logic [EIDX_W-1:0]   entry_index;
  } out_item_t;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic              lookup;
  } cmd_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

endpackage

[src/mmdt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmdt_front - request intake and classification
// Accept requests while the queue has room and tag each as lookup or ignored.
// ----------------------------------------------------------------------------
module mmdt_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  mmdt_pkg::in_item_t in_data,
  input  mmdt_pkg::q_stat_t  q_stat,
  output logic               push,
  output mmdt_pkg::cmd_t     push_cmd
);

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Only an event with both a bridge master and a MAC touches the table
  always_comb begin
    push_cmd.mac    = in_data.mac_address;
    push_cmd.port   = in_data.port_number;
    push_cmd.lookup = in_data.has_master && in_data.has_mac;
  end

endmodule

[src/mmdt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmdt_queue - short request queue between front and back end
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mmdt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mmdt_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output mmdt_pkg::cmd_t    head_cmd,
  output mmdt_pkg::q_stat_t q_stat
);

  localparam int unsigned PTR_W = $clog2(mmdt_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(mmdt_pkg::QUEUE_DEPTH + 1);

  mmdt_pkg::cmd_t   slot_r [mmdt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(mmdt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(mmdt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd     = slot_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == CNT_W'(mmdt_pkg::QUEUE_DEPTH));

endmodule

[src/mmdt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmdt_back - table search, update and result register
// Scan the filled slots one per cycle, then update the table and report; ignored requests skip the scan.
// ----------------------------------------------------------------------------
module mmdt_back #(
  parameter int unsigned TABLE_DEPTH = mmdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mmdt_pkg::q_stat_t   q_stat,
  input  mmdt_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mmdt_pkg::out_item_t out_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Table memories, read data registered
  logic [mmdt_pkg::MAC_W-1:0]  addr_mem [TABLE_DEPTH];
  logic [mmdt_pkg::PORT_W-1:0] port_mem [TABLE_DEPTH];

  mmdt_pkg::back_state_t       state_r, state_nxt;
  mmdt_pkg::cmd_t              cmd_r;
  logic [CNT_W-1:0]            rd_idx_r;
  logic                        cmp_vld_r;
  logic [IDX_W-1:0]            cmp_idx_r;
  logic [mmdt_pkg::MAC_W-1:0]  addr_q_r;
  logic [mmdt_pkg::PORT_W-1:0] port_q_r;
  logic [CNT_W-1:0]            count_r;
  logic                        out_valid_r;
  mmdt_pkg::out_item_t         out_data_r;

  logic                        out_free;
  logic                        start;
  logic                        rd_en;
  logic                        hit;
  logic                        miss;
  logic                        tbl_full;
  logic                        port_we;
  logic                        addr_we;
  logic [IDX_W-1:0]            wr_idx;
  logic                        load;
  mmdt_pkg::out_item_t         res;

  assign out_free = !out_valid_r || !out_stall;
  assign tbl_full = (count_r == CNT_W'(TABLE_DEPTH));
  assign hit      = (state_r == mmdt_pkg::BK_SCAN) && cmp_vld_r && (addr_q_r == cmd_r.mac);
  assign miss     = (state_r == mmdt_pkg::BK_SCAN) && !cmp_vld_r && (rd_idx_r >= count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmdt_pkg::BK_IDLE: begin
        if (!q_stat.empty && out_free && head_cmd.lookup) begin
          state_nxt = mmdt_pkg::BK_SCAN;
        end
      end
      mmdt_pkg::BK_SCAN: begin
        if (hit || miss) begin
          state_nxt = mmdt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = mmdt_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    pop     = 1'b0;
    start   = 1'b0;
    rd_en   = 1'b0;
    port_we = 1'b0;
    addr_we = 1'b0;
    wr_idx  = cmp_idx_r;
    load    = 1'b0;
    res     = '0;
    unique case (state_r)
      mmdt_pkg::BK_IDLE: begin
        if (!q_stat.empty && out_free) begin
          pop = 1'b1;
          if (head_cmd.lookup) begin
            start = 1'b1;
          end else begin
            load       = 1'b1;
            res.status = mmdt_pkg::ST_IGNORED;
          end
        end
      end
      mmdt_pkg::BK_SCAN: begin
        rd_en = !hit && (rd_idx_r < count_r);
        if (hit) begin
          load            = 1'b1;
          res.entry_index = mmdt_pkg::EIDX_W'(cmp_idx_r);
          if (port_q_r != cmd_r.port) begin
            port_we           = 1'b1;
            res.status        = mmdt_pkg::ST_MOVED;
            res.previous_port = port_q_r;
          end else begin
            res.status = mmdt_pkg::ST_HIT;
          end
        end else if (miss) begin
          load = 1'b1;
          if (tbl_full) begin
            res.status = mmdt_pkg::ST_FULL;
          end else begin
            wr_idx          = count_r[IDX_W-1:0];
            port_we         = 1'b1;
            addr_we         = 1'b1;
            res.status      = mmdt_pkg::ST_LEARNED;
            res.entry_index = mmdt_pkg::EIDX_W'(count_r[IDX_W-1:0]);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmdt_pkg::BK_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (addr_we) begin
        count_r <= count_r + 1'b1;
      end
      if (start) begin
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
      end else begin
        cmp_vld_r <= rd_en;
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= head_cmd;
    end
    if (rd_en) begin
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (load) begin
      out_data_r <= res;
    end
  end

  // Table memories
  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[wr_idx] <= cmd_r.mac;
    end
    if (port_we) begin
      port_mem[wr_idx] <= cmd_r.port;
    end
    if (rd_en) begin
      addr_q_r <= addr_mem[rd_idx_r[IDX_W-1:0]];
      port_q_r <= port_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/mac_move_detect_table.sv]
`timescale 1ns / 1ps
// An ignored request passes the queue and the result register to reach the output;
// a lookup also scans the filled slots, ending at the first match or the last slot.
// Lookups are served one at a time, set by the single read port of the table memories,
// which the search walks one slot per cycle; ignored requests go 1 a cycle if not stalled.
// Reset: synchronous, active low; empties the queue and clears the entry count.
// Table contents are not cleared; slots at or above the count are never read.
// ----------------------------------------------------------------------------
// mac_move_detect_table - learned MAC table with move detection
// Front end classifies events, a short queue decouples it from the back end,
// which searches the table, learns new stations and flags port moves.
// ----------------------------------------------------------------------------
module mac_move_detect_table #(
  parameter int unsigned TABLE_DEPTH = mmdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  mmdt_pkg::in_item_t  in_data,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output mmdt_pkg::out_item_t out_data
);

  // Front to queue
  logic              push;
  mmdt_pkg::cmd_t    push_cmd;
  // Queue to back end
  logic              pop;
  mmdt_pkg::cmd_t    head_cmd;
  mmdt_pkg::q_stat_t q_stat;

  // Accept requests and tag those that qualify for a table lookup;
  // stall the requester only when the queue is full.
  mmdt_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Hold pending requests so intake keeps going while the back end
  // searches or while a result waits on a stalled consumer.
  mmdt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // Search the filled slots from slot zero upward, stop at the first match,
  // then update the port on a move or append on a miss if there is room; drive the result
  // from a register so the consumer may stall freely.
  mmdt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
